// ----- rtl/dpoa_pkg.sv -----
// Shared types and codes for the dual port owner arbiter.
`default_nettype none

package dpoa_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned PORT_W = 2;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_POLL    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOCK    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNLOCK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SWITCH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd4;

  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACTIVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOCKED = 2'd2;

  localparam logic [PORT_W-1:0] PORT_NONE   = 2'd0;
  localparam logic [PORT_W-1:0] PORT_FIRST  = 2'd1;
  localparam logic [PORT_W-1:0] PORT_SECOND = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_TIMEOUT = 1'd1;

  localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RESET = 32'd5000;
  localparam logic [TIME_W-1:0] LOCK_TIMEOUT_RESET = 32'd10000;

  typedef struct packed {
    logic [TIME_W-1:0] idle_timeout_ms;
    logic [TIME_W-1:0] lock_timeout_ms;
  } timeouts_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] now_ms;
    logic              first_has_data;
    logic              second_has_data;
    logic [PORT_W-1:0] port;
  } request_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PORT_W-1:0] owner;
    logic [TIME_W-1:0] activity_stamp;
    logic [TIME_W-1:0] lock_stamp;
    logic              first_pending;
    logic              second_pending;
  } arb_state_t;

  typedef struct packed {
    logic [PORT_W-1:0] owner;
    logic [MODE_W-1:0] mode;
    logic              accepted;
    logic              first_pending;
    logic              second_pending;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/dpoa_cfg.sv -----
// Timeout configuration registers.
`default_nettype none

module dpoa_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [dpoa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dpoa_pkg::TIME_W-1:0]    cfg_data,
  output dpoa_pkg::timeouts_t                 timeouts
);
  import dpoa_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeouts.idle_timeout_ms <= IDLE_TIMEOUT_RESET;
      timeouts.lock_timeout_ms <= LOCK_TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IDLE_TIMEOUT: timeouts.idle_timeout_ms <= cfg_data;
        REG_LOCK_TIMEOUT: timeouts.lock_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dpoa_step.sv -----
// Next-state and result logic for one request.
`default_nettype none

module dpoa_step (
  input  wire dpoa_pkg::arb_state_t state,
  input  wire dpoa_pkg::request_t   req,
  input  wire dpoa_pkg::timeouts_t  timeouts,
  output dpoa_pkg::arb_state_t      state_next,
  output dpoa_pkg::result_t         result
);
  import dpoa_pkg::*;

  logic [PORT_W-1:0] tgt;
  logic [TIME_W-1:0] lock_elapsed;
  logic [TIME_W-1:0] act_elapsed;
  logic              lock_late;
  logic              idle_late;
  logic              f;
  logic              s;
  logic              own;
  logic              other;
  logic [PORT_W-1:0] other_port;
  logic              owner_real;
  logic              accepted;
  arb_state_t        nx;

  assign f   = req.first_has_data;
  assign s   = req.second_has_data;
  assign tgt = (req.port == PORT_FIRST || req.port == PORT_SECOND) ? req.port : PORT_NONE;

  // wrapping elapsed time
  assign lock_elapsed = req.now_ms - state.lock_stamp;
  assign act_elapsed  = req.now_ms - state.activity_stamp;
  assign lock_late    = lock_elapsed >= timeouts.lock_timeout_ms;
  assign idle_late    = act_elapsed >= timeouts.idle_timeout_ms;

  assign owner_real = state.owner == PORT_FIRST || state.owner == PORT_SECOND;
  assign own        = (state.owner == PORT_FIRST) ? f : s;
  assign other      = (state.owner == PORT_FIRST) ? s : f;
  assign other_port = (state.owner == PORT_FIRST) ? PORT_SECOND : PORT_FIRST;

  always_comb begin
    nx       = state;
    accepted = 1'b1;
    unique case (req.cmd)
      CMD_POLL: begin
        if (f) nx.first_pending = 1'b1;
        if (s) nx.second_pending = 1'b1;
        if (state.mode == MODE_LOCKED && lock_late) nx.mode = MODE_ACTIVE;
        if (nx.mode == MODE_IDLE) begin
          if (f) begin
            nx.owner          = PORT_FIRST;
            nx.mode           = MODE_ACTIVE;
            nx.activity_stamp = req.now_ms;
          end else if (s) begin
            nx.owner          = PORT_SECOND;
            nx.mode           = MODE_ACTIVE;
            nx.activity_stamp = req.now_ms;
          end
        end else if (nx.mode == MODE_ACTIVE) begin
          if (owner_real) begin
            priority if (own) begin
              nx.activity_stamp = req.now_ms;
            end else if (other && idle_late) begin
              nx.owner          = other_port;
              nx.activity_stamp = req.now_ms;
            end else if (!other && idle_late) begin
              nx.mode = MODE_IDLE;
            end else begin
              // hold until the idle timeout
            end
          end
        end else begin
          if ((state.owner == PORT_FIRST && f) || (state.owner == PORT_SECOND && s))
            nx.lock_stamp = req.now_ms;
        end
        if (nx.owner == PORT_FIRST && !f) nx.first_pending = 1'b0;
        if (nx.owner == PORT_SECOND && !s) nx.second_pending = 1'b0;
      end
      CMD_LOCK: begin
        if (state.mode == MODE_LOCKED && state.owner != tgt) begin
          accepted = 1'b0;
        end else begin
          nx.mode       = MODE_LOCKED;
          nx.owner      = tgt;
          nx.lock_stamp = req.now_ms;
        end
      end
      CMD_UNLOCK: begin
        if (state.mode == MODE_LOCKED) begin
          nx.mode           = MODE_ACTIVE;
          nx.activity_stamp = req.now_ms;
        end
      end
      CMD_SWITCH: begin
        if (state.mode == MODE_LOCKED) begin
          accepted = 1'b0;
        end else begin
          if (tgt != PORT_NONE) nx.owner = tgt;
          nx.mode           = MODE_ACTIVE;
          nx.activity_stamp = req.now_ms;
        end
      end
      CMD_REFRESH: begin
        if (state.owner == tgt) begin
          nx.activity_stamp = req.now_ms;
          if (state.mode == MODE_LOCKED) nx.lock_stamp = req.now_ms;
        end
      end
      default: ;
    endcase
  end

  assign state_next            = nx;
  assign result.owner          = nx.owner;
  assign result.mode           = nx.mode;
  assign result.accepted       = accepted;
  assign result.first_pending  = nx.first_pending;
  assign result.second_pending = nx.second_pending;

endmodule

`default_nettype wire

// ----- rtl/dual_port_owner_arbiter.sv -----
// Top level of the dual port owner arbiter.
`default_nettype none

// Two-port console ownership arbiter. Each request (poll, lock, unlock,
// switch, refresh) is captured in an input register, evaluated against the
// arbiter state by combinational compare-and-update logic, and its result is
// held in an output register until taken. One request is accepted every
// cycle while results are taken, set by the single state update per cycle.
// Timeouts compare the wrapping 32-bit difference between now_ms and the
// stored stamps.
module dual_port_owner_arbiter (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output wire logic                           cfg_ready,
  input  wire logic [dpoa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dpoa_pkg::TIME_W-1:0]    cfg_data,
  input  wire logic                           in_valid,
  output wire logic                           in_ready,
  input  wire logic [dpoa_pkg::CMD_W-1:0]     cmd,
  input  wire logic [dpoa_pkg::TIME_W-1:0]    now_ms,
  input  wire logic                           first_has_data,
  input  wire logic                           second_has_data,
  input  wire logic [dpoa_pkg::PORT_W-1:0]    port,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [dpoa_pkg::PORT_W-1:0]         owner,
  output logic [dpoa_pkg::MODE_W-1:0]         mode,
  output logic                                accepted,
  output logic                                first_pending,
  output logic                                second_pending
);
  import dpoa_pkg::*;

  timeouts_t  timeouts;
  request_t   req;
  logic       req_valid;
  arb_state_t state;
  arb_state_t state_next;
  result_t    result;
  logic       fire;

  assign cfg_ready = 1'b1;

  dpoa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .timeouts  (timeouts)
  );

  assign fire     = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req.cmd             <= cmd;
      req.now_ms          <= now_ms;
      req.first_has_data  <= first_has_data;
      req.second_has_data <= second_has_data;
      req.port            <= port;
    end
  end

  dpoa_step u_step (
    .state      (state),
    .req        (req),
    .timeouts   (timeouts),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode           <= MODE_IDLE;
      state.owner          <= PORT_FIRST;
      state.activity_stamp <= '0;
      state.lock_stamp     <= '0;
      state.first_pending  <= 1'b0;
      state.second_pending <= 1'b0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      owner          <= result.owner;
      mode           <= result.mode;
      accepted       <= result.accepted;
      first_pending  <= result.first_pending;
      second_pending <= result.second_pending;
    end
  end

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("result missing after step");

  a_state_mode_legal: assert property (@(posedge clk) disable iff (rst)
    state.mode != 2'd3 && state.owner != 2'd3)
    else $error("illegal arbiter state");

  a_refusal_cmd: assert property (@(posedge clk) disable iff (rst)
    fire && !result.accepted |-> req.cmd == CMD_LOCK || req.cmd == CMD_SWITCH)
    else $error("refusal on non lock/switch request");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !req_valid |-> in_ready)
    else $error("input stalled while empty");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Testbench for the dual port owner arbiter: directed and random requests checked against a built-in model.
`timescale 1ns / 1ps

module tb_top;
  import dpoa_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0]  CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0]  CMD_RSVD7 = 3'd7;
  localparam logic [PORT_W-1:0] PORT_RSVD = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int MAX_PRINTS = 50;

  logic clk;
  logic rst = 1'b1;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IDLE_TIMEOUT;
  logic [TIME_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd = CMD_POLL;
  logic [TIME_W-1:0]    now_ms = '0;
  logic                 first_has_data = 1'b0;
  logic                 second_has_data = 1'b0;
  logic [PORT_W-1:0]    port = PORT_NONE;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PORT_W-1:0]    owner;
  logic [MODE_W-1:0]    mode;
  logic                 accepted;
  logic                 first_pending;
  logic                 second_pending;

  arb_state_t        arb;
  timeouts_t         tmo;
  result_t           grant_q[$];
  int                errors = 0;
  int unsigned       cycles = 0;
  int                hold_requests = 0;
  bit                sender_gaps = 1'b1;
  bit                sink_gaps = 1'b1;
  logic [TIME_W-1:0] clock_ms = 32'd1000;

  dual_port_owner_arbiter i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .now_ms         (now_ms),
    .first_has_data (first_has_data),
    .second_has_data(second_has_data),
    .port           (port),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .owner          (owner),
    .mode           (mode),
    .accepted       (accepted),
    .first_pending  (first_pending),
    .second_pending (second_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic bit expired(input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] stamp,
                                 input logic [TIME_W-1:0] limit);
    logic [TIME_W-1:0] elapsed;
    elapsed = t - stamp;
    return elapsed >= limit;
  endfunction

  // Applies one request to the arbiter state and returns the outcome.
  function automatic result_t arbitrate(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] t,
                                        input logic f, input logic s,
                                        input logic [PORT_W-1:0] p_in);
    logic [PORT_W-1:0] p;
    logic              grant;
    logic              own, other, late;
    logic [PORT_W-1:0] other_port;
    result_t           r;
    p = (p_in == PORT_FIRST || p_in == PORT_SECOND) ? p_in : PORT_NONE;
    grant = 1'b1;
    case (c)
      CMD_POLL: begin
        if (f) arb.first_pending = 1'b1;
        if (s) arb.second_pending = 1'b1;
        if (arb.mode == MODE_LOCKED && expired(t, arb.lock_stamp, tmo.lock_timeout_ms))
          arb.mode = MODE_ACTIVE;
        if (arb.mode == MODE_IDLE) begin
          if (f) begin
            arb.owner = PORT_FIRST;
            arb.mode = MODE_ACTIVE;
            arb.activity_stamp = t;
          end else if (s) begin
            arb.owner = PORT_SECOND;
            arb.mode = MODE_ACTIVE;
            arb.activity_stamp = t;
          end
        end else if (arb.mode == MODE_ACTIVE) begin
          if (arb.owner == PORT_FIRST || arb.owner == PORT_SECOND) begin
            own = (arb.owner == PORT_FIRST) ? f : s;
            other = (arb.owner == PORT_FIRST) ? s : f;
            other_port = (arb.owner == PORT_FIRST) ? PORT_SECOND : PORT_FIRST;
            late = expired(t, arb.activity_stamp, tmo.idle_timeout_ms);
            if (own) begin
              arb.activity_stamp = t;
            end else if (other && late) begin
              arb.owner = other_port;
              arb.activity_stamp = t;
            end else if (!other && late) begin
              arb.mode = MODE_IDLE;
            end
          end
        end else begin
          if ((arb.owner == PORT_FIRST && f) || (arb.owner == PORT_SECOND && s))
            arb.lock_stamp = t;
        end
        if (arb.owner == PORT_FIRST && !f) arb.first_pending = 1'b0;
        if (arb.owner == PORT_SECOND && !s) arb.second_pending = 1'b0;
      end
      CMD_LOCK: begin
        if (arb.mode == MODE_LOCKED && arb.owner != p) begin
          grant = 1'b0;
        end else begin
          arb.mode = MODE_LOCKED;
          arb.owner = p;
          arb.lock_stamp = t;
        end
      end
      CMD_UNLOCK: begin
        if (arb.mode == MODE_LOCKED) begin
          arb.mode = MODE_ACTIVE;
          arb.activity_stamp = t;
        end
      end
      CMD_SWITCH: begin
        if (arb.mode == MODE_LOCKED) begin
          grant = 1'b0;
        end else begin
          if (p != PORT_NONE) arb.owner = p;
          arb.mode = MODE_ACTIVE;
          arb.activity_stamp = t;
        end
      end
      CMD_REFRESH: begin
        if (arb.owner == p) begin
          arb.activity_stamp = t;
          if (arb.mode == MODE_LOCKED) arb.lock_stamp = t;
        end
      end
      default: ;
    endcase
    r.owner = arb.owner;
    r.mode = arb.mode;
    r.accepted = grant;
    r.first_pending = arb.first_pending;
    r.second_pending = arb.second_pending;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      arb.mode = MODE_IDLE;
      arb.owner = PORT_FIRST;
      arb.activity_stamp = '0;
      arb.lock_stamp = '0;
      arb.first_pending = 1'b0;
      arb.second_pending = 1'b0;
      tmo = {IDLE_TIMEOUT_RESET, LOCK_TIMEOUT_RESET};
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IDLE_TIMEOUT: tmo.idle_timeout_ms = cfg_data;
          REG_LOCK_TIMEOUT: tmo.lock_timeout_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        grant_q.push_back(arbitrate(cmd, now_ms, first_has_data, second_has_data, port));
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (grant_q.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 0);
      end else begin
        want = grant_q.pop_front();
        if (owner !== want.owner) report_mismatch("owner", owner, want.owner);
        if (mode !== want.mode) report_mismatch("mode", mode, want.mode);
        if (accepted !== want.accepted) report_mismatch("accepted", accepted, want.accepted);
        if (first_pending !== want.first_pending)
          report_mismatch("first_pending", first_pending, want.first_pending);
        if (second_pending !== want.second_pending)
          report_mismatch("second_pending", second_pending, want.second_pending);
      end
    end
  end

  // Result side: random short stalls, plus long hold-offs on request.
  initial begin : sink
    int gap = 0;
    int hold = 0;
    int holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_req(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] t,
                          input logic f, input logic s, input logic [PORT_W-1:0] p);
    int gap;
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    now_ms <= t;
    first_has_data <= f;
    second_has_data <= s;
    port <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(input logic [TIME_W-1:0] step);
    int pick;
    logic [CMD_W-1:0]  c;
    logic [PORT_W-1:0] p;
    pick = $urandom_range(0, 99);
    if (pick < 55)      c = CMD_POLL;
    else if (pick < 67) c = CMD_LOCK;
    else if (pick < 75) c = CMD_UNLOCK;
    else if (pick < 87) c = CMD_SWITCH;
    else if (pick < 97) c = CMD_REFRESH;
    else if (pick == 97) c = CMD_RSVD5;
    else if (pick == 98) c = CMD_RSVD6;
    else                 c = CMD_RSVD7;
    pick = $urandom_range(0, 99);
    if (pick < 4)      clock_ms = $urandom;
    else if (pick < 7) clock_ms = clock_ms - $urandom_range(0, step);
    else               clock_ms = clock_ms + $urandom_range(0, step);
    pick = $urandom_range(0, 9);
    if (pick < 4)       p = PORT_FIRST;
    else if (pick < 8)  p = PORT_SECOND;
    else if (pick == 8) p = PORT_NONE;
    else                p = PORT_RSVD;
    send_req(c, clock_ms, $urandom_range(0, 4) < 2, $urandom_range(0, 4) < 2, p);
  endtask

  // Wait until every request has come back and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (grant_q.size() == 0) break;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_cases();
    send_req(CMD_POLL,    32'd0,     1'b0, 1'b0, PORT_NONE);
    send_req(CMD_POLL,    32'd10,    1'b0, 1'b1, PORT_NONE);
    send_req(CMD_POLL,    32'd20,    1'b0, 1'b1, PORT_FIRST);
    send_req(CMD_POLL,    32'd100,   1'b1, 1'b0, PORT_NONE);
    send_req(CMD_POLL,    32'd6000,  1'b1, 1'b0, PORT_NONE);
    send_req(CMD_POLL,    32'd20000, 1'b0, 1'b0, PORT_NONE);
    send_req(CMD_LOCK,    32'd20010, 1'b0, 1'b0, PORT_RSVD);
    send_req(CMD_POLL,    32'd20020, 1'b1, 1'b1, PORT_NONE);
    send_req(CMD_LOCK,    32'd20025, 1'b0, 1'b0, PORT_FIRST);
    send_req(CMD_LOCK,    32'd20030, 1'b0, 1'b0, PORT_NONE);
    send_req(CMD_POLL,    32'd40000, 1'b0, 1'b0, PORT_NONE);
    send_req(CMD_UNLOCK,  32'd40005, 1'b0, 1'b0, PORT_NONE);
    send_req(CMD_SWITCH,  32'd40010, 1'b0, 1'b0, PORT_NONE);
    send_req(CMD_SWITCH,  32'd40020, 1'b0, 1'b0, PORT_SECOND);
    send_req(CMD_LOCK,    32'd40030, 1'b0, 1'b0, PORT_SECOND);
    send_req(CMD_SWITCH,  32'd40040, 1'b0, 1'b0, PORT_FIRST);
    send_req(CMD_REFRESH, 32'd40050, 1'b0, 1'b0, PORT_FIRST);
    send_req(CMD_REFRESH, 32'd40060, 1'b0, 1'b0, PORT_SECOND);
    send_req(CMD_POLL,    32'd40070, 1'b1, 1'b1, PORT_NONE);
    send_req(CMD_UNLOCK,  32'd40080, 1'b0, 1'b0, PORT_NONE);
    send_req(CMD_RSVD5,   32'hFFFF_FFFF, 1'b1, 1'b1, PORT_RSVD);
    send_req(CMD_RSVD6,   32'hAAAA_5555, 1'b0, 1'b1, PORT_FIRST);
    send_req(CMD_RSVD7,   32'h5555_AAAA, 1'b1, 1'b0, PORT_SECOND);
    send_req(CMD_POLL,    32'hFFFF_FFF0, 1'b1, 1'b0, PORT_NONE);
    send_req(CMD_POLL,    32'h0000_1400, 1'b0, 1'b1, PORT_NONE);
  endtask

  task automatic test_timeout_extremes();
    write_reg(REG_IDLE_TIMEOUT, '0);
    write_reg(REG_LOCK_TIMEOUT, '0);
    repeat (30) send_random(32'd50);
    write_reg(REG_IDLE_TIMEOUT, '1);
    write_reg(REG_LOCK_TIMEOUT, '1);
    // elapsed of all ones is the only value that reaches a full-scale timeout
    send_req(CMD_SWITCH, 32'h8000_0000, 1'b0, 1'b0, PORT_FIRST);
    send_req(CMD_POLL,   32'h7FFF_FFFF, 1'b0, 1'b1, PORT_NONE);
    send_req(CMD_POLL,   32'h7FFF_FFFE, 1'b0, 1'b0, PORT_NONE);
    send_req(CMD_LOCK,   32'h0000_0010, 1'b0, 1'b0, PORT_SECOND);
    send_req(CMD_POLL,   32'h0000_000F, 1'b1, 1'b0, PORT_NONE);
    repeat (30) send_random(32'd1000);
  endtask

  task automatic test_backpressure();
    write_reg(REG_IDLE_TIMEOUT, 32'd80);
    write_reg(REG_LOCK_TIMEOUT, 32'd150);
    sender_gaps = 1'b0;
    hold_requests++;
    repeat (40) send_random(32'd40);
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [TIME_W-1:0] idle_to;
    logic [TIME_W-1:0] lock_to;
    logic [TIME_W-1:0] step;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 4) begin
        idle_to = $urandom;
        lock_to = $urandom;
        step = '1;
      end else begin
        idle_to = $urandom_range(10, 300);
        lock_to = $urandom_range(10, 600);
        step = idle_to / 2 + 1;
      end
      write_reg(REG_IDLE_TIMEOUT, idle_to);
      write_reg(REG_LOCK_TIMEOUT, lock_to);
      if (ph == 5) begin
        sender_gaps = 1'b0;
        sink_gaps = 1'b0;
      end
      repeat (300) send_random(step);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_timeout_extremes();
    test_backpressure();
    test_random_traffic();
    settle();
    repeat (4) @(posedge clk);
    if (grant_q.size() != 0) report_mismatch("results never returned", grant_q.size(), 0);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dpoa_pkg.sv
rtl/dpoa_cfg.sv
rtl/dpoa_step.sv
rtl/dual_port_owner_arbiter.sv
verif/tb_top.sv
